### hdl/ged_pkg.sv
// ----------------------------------------------------------------------------
// ged_pkg
// shared types, constants and helpers of the gradient edge detector
// ----------------------------------------------------------------------------
package ged_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
  localparam int PEND_W    = $clog2(MAX_WIDTH + 2);
  localparam int ROW_W     = 12;
  localparam int NUM_LANES = 3;

  localparam logic [1:0] OP_ROBERTS = 2'd0;
  localparam logic [1:0] OP_PREWITT = 2'd1;
  localparam logic [1:0] DIR_X      = 2'd0;
  localparam logic [1:0] DIR_Y      = 2'd1;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_OPERATOR,
    REG_DIRECTION
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_START,
    S_CALC
  } seq_state_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_GRAD,
    L_SUM,
    L_ROOT,
    L_DONE
  } lane_state_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] edge_red;
    logic [7:0] edge_green;
    logic [7:0] edge_blue;
    logic       end_of_row;
    logic       end_of_frame;
  } result_t;

  typedef struct packed {
    logic       start;
    logic [1:0] operator_kind;
    logic [1:0] gradient_direction;
  } lane_ctrl_t;

  typedef logic [8:0][7:0] win_bytes_t;

  function automatic logic [1:0] slot_next(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_prev(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

### hdl/ged_ram.sv
// ----------------------------------------------------------------------------
// ged_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ged_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/ged_lane.sv
// ----------------------------------------------------------------------------
// ged_lane
// one color channel: gradient, optional magnitude root, saturation
// ----------------------------------------------------------------------------
module ged_lane (
  input  logic                clk,
  input  logic                rst,
  input  ged_pkg::lane_ctrl_t ctrl,
  input  ged_pkg::win_bytes_t win,
  output logic                done,
  output logic [7:0]          value
);
  import ged_pkg::*;

  lane_state_t state, state_next;

  logic [9:0]  gx, gy;
  logic [19:0] sqx, sqy;
  logic [20:0] sum;
  logic [15:0] rad;
  logic [9:0]  rem;
  logic [7:0]  root;
  logic [2:0]  cnt;
  logic [1:0]  dir;

  logic [9:0]  a_x, b_x, a_y, b_y, gx_c, gy_c;
  logic [11:0] rem_sh, test;
  logic [9:0]  rem_n;
  logic [7:0]  root_n;

  always_comb begin
    logic [9:0] t1, t3, t5, t7;
    t1 = (ctrl.operator_kind == OP_PREWITT) ? 10'(win[1]) : {1'b0, win[1], 1'b0};
    t3 = (ctrl.operator_kind == OP_PREWITT) ? 10'(win[3]) : {1'b0, win[3], 1'b0};
    t5 = (ctrl.operator_kind == OP_PREWITT) ? 10'(win[5]) : {1'b0, win[5], 1'b0};
    t7 = (ctrl.operator_kind == OP_PREWITT) ? 10'(win[7]) : {1'b0, win[7], 1'b0};
    if (ctrl.operator_kind == OP_ROBERTS) begin
      a_x = 10'(win[8]);
      b_x = 10'(win[4]);
      a_y = 10'(win[5]);
      b_y = 10'(win[7]);
    end else begin
      a_x = 10'(win[0]) + t1 + 10'(win[2]);
      b_x = 10'(win[6]) + t7 + 10'(win[8]);
      a_y = 10'(win[0]) + t3 + 10'(win[6]);
      b_y = 10'(win[2]) + t5 + 10'(win[8]);
    end
    gx_c = (a_x > b_x) ? a_x - b_x : b_x - a_x;
    gy_c = (a_y > b_y) ? a_y - b_y : b_y - a_y;
  end

  always_comb begin
    sum = 21'(sqx) + 21'(sqy);
  end

  always_comb begin
    rem_sh = {rem, rad[15:14]};
    test   = {2'b00, root, 2'b01};
    if (rem_sh >= test) begin
      rem_n  = 10'(rem_sh - test);
      root_n = {root[6:0], 1'b1};
    end else begin
      rem_n  = rem_sh[9:0];
      root_n = {root[6:0], 1'b0};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      L_IDLE, L_DONE: if (ctrl.start) state_next = L_GRAD;
      L_GRAD: state_next = (dir == DIR_X || dir == DIR_Y) ? L_DONE : L_SUM;
      L_SUM:  state_next = (sum >= 21'd65025) ? L_DONE : L_ROOT;
      L_ROOT: if (cnt == 3'd0) state_next = L_DONE;
      default: state_next = L_IDLE;
    endcase
  end

  always_comb begin
    done = (state == L_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE, L_DONE: begin
        if (ctrl.start) begin
          gx  <= gx_c;
          gy  <= gy_c;
          dir <= ctrl.gradient_direction;
        end
      end
      L_GRAD: begin
        sqx <= 20'(gx * gx);
        sqy <= 20'(gy * gy);
        if (dir == DIR_X) begin
          value <= (gx > 10'd255) ? 8'hff : gx[7:0];
        end else if (dir == DIR_Y) begin
          value <= (gy > 10'd255) ? 8'hff : gy[7:0];
        end
      end
      L_SUM: begin
        if (sum >= 21'd65025) value <= 8'hff;
        rad  <= sum[15:0];
        rem  <= '0;
        root <= '0;
        cnt  <= 3'd7;
      end
      L_ROOT: begin
        rad  <= {rad[13:0], 2'b00};
        rem  <= rem_n;
        root <= root_n;
        cnt  <= cnt - 3'd1;
        if (cnt == 3'd0) value <= root_n;
      end
      default: ;
    endcase
  end

endmodule

### hdl/gradient_edge_detector.sv
// ----------------------------------------------------------------------------
// gradient_edge_detector
// roberts, prewitt and sobel edge detection on rgb pixels, one lane per color
// ----------------------------------------------------------------------------
// pixel beats enter on pixel/pixel_valid/pixel_stall in raster order, one
// edge pixel leaves on result/result_valid/result_stall for each of them,
// trailing the input by image_width+1 pixels. after the frame's last pixel,
// drain beats (operation 1) push out the remaining results, one each; a
// drain beat with nothing pending, or inside a frame, gives nothing.
// registers: image_width, image_height, operator_kind, gradient_direction
// at byte addresses 0, 4, 8, 12 of the apb port; write them only while idle.
// each beat is handled by a sequencer: a pixel write and reads of the three
// row rams, then the color lanes run (gradient only for x or y, combined
// magnitude with its 8-step root). a pixel beat without result only writes
// it; pixel_stall holds further beats until the sequencer is idle again.
// results sit in an output register; while the receiver stalls, beats without
// result still go in, and a beat with a result waits until the register frees.
// reset (rst, synchronous) returns positions, counters and registers to their
// defaults; row ram contents are left as they are.
// ----------------------------------------------------------------------------
module gradient_edge_detector (
  input  logic             clk,
  input  logic             rst,
  input  ged_pkg::pixel_t  pixel,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  output ged_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ged_pkg::*;

  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [1:0]  operator_kind;
  logic [1:0]  gradient_direction;

  seq_state_t state, state_next;

  logic [COL_W-1:0]  column_count, out_col, wr_addr;
  logic [ROW_W-1:0]  row_count, out_row;
  logic [PEND_W-1:0] pending_results;
  logic [1:0]        in_slot, out_slot, wr_slot;
  logic [23:0]       wr_data;
  logic              emit_q, wr_q;

  logic [WCNT_W-1:0] eff_w;
  logic [12:0]       eff_h;
  logic              accept, is_drain, emit_now, col_last, in_last_row;
  logic              out_eor, out_eof, all_done, out_free, we;
  logic [COL_W-1:0]  cols [3];
  logic [COL_W-1:0]  raddr;
  logic [1:0]        rows [3];
  logic [23:0]       rdata [3];
  logic [23:0]       window_pixels [9];
  logic [1:0]        rd_col;
  win_bytes_t        lane_win [NUM_LANES];
  logic [7:0]        lane_val [NUM_LANES];
  logic [NUM_LANES-1:0] lane_done;
  lane_ctrl_t        lane_ctrl;
  reg_idx_t          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:     prdata = 32'(image_width);
      REG_HEIGHT:    prdata = 32'(image_height);
      REG_OPERATOR:  prdata = 32'(operator_kind);
      REG_DIRECTION: prdata = 32'(gradient_direction);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= 12'd640;
      image_height       <= 13'd480;
      operator_kind      <= 2'd0;
      gradient_direction <= 2'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_WIDTH:     image_width        <= pwdata[11:0];
        REG_HEIGHT:    image_height       <= pwdata[12:0];
        REG_OPERATOR:  operator_kind      <= pwdata[1:0];
        REG_DIRECTION: gradient_direction <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) eff_w = WCNT_W'(1);
    else if (32'(image_width) > MAX_WIDTH) eff_w = WCNT_W'(MAX_WIDTH);
    else eff_w = WCNT_W'(image_width);
    eff_h = (image_height == '0) ? 13'd1 : image_height;
  end

  // input side
  assign pixel_stall = (state != S_IDLE);
  assign accept      = pixel_valid && !pixel_stall;
  assign is_drain    = pixel.operation;
  assign col_last    = (32'(column_count) + 1 >= 32'(eff_w));
  assign in_last_row = (32'(row_count) + 1 >= 32'(eff_h));
  always_comb begin
    if (is_drain) begin
      emit_now = (pending_results != '0) && (column_count == '0) && (row_count == '0);
    end else begin
      emit_now = (32'(pending_results) > 32'(eff_w));
    end
  end

  // output position and window geometry
  assign out_eor = (32'(out_col) + 1 >= 32'(eff_w));
  assign out_eof = out_eor && (32'(out_row) + 1 >= 32'(eff_h));

  always_comb begin
    cols[0] = (out_col == '0) ? out_col : out_col - COL_W'(1);
    cols[1] = out_col;
    cols[2] = out_eor ? out_col : out_col + COL_W'(1);
    rows[0] = (out_row == '0) ? out_slot : slot_prev(out_slot);
    rows[1] = out_slot;
    rows[2] = (32'(out_row) + 1 >= 32'(eff_h)) ? out_slot : slot_next(out_slot);
  end

  always_comb begin
    unique case (state)
      S_RD1:   raddr = cols[1];
      S_RD2:   raddr = cols[2];
      default: raddr = cols[0];
    endcase
    unique case (state)
      S_RD2:   rd_col = 2'd1;
      S_RD3:   rd_col = 2'd2;
      default: rd_col = 2'd0;
    endcase
  end

  assign we = (state == S_WR) || (state == S_START && wr_q);

  for (genvar s = 0; s < 3; s++) begin : g_row
    ged_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_row (
      .clk   (clk),
      .we    (we && (wr_slot == 2'(s))),
      .waddr (wr_addr),
      .wdata (wr_data),
      .raddr (raddr),
      .rdata (rdata[s])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) window_pixels[k] <= '0;
    end else if (state == S_RD1 || state == S_RD2 || state == S_RD3) begin
      for (int r = 0; r < 3; r++) begin
        window_pixels[r * 3 + 32'(rd_col)] <= rdata[rows[r]];
      end
    end
  end

  // color lanes
  assign lane_ctrl.start              = (state == S_START);
  assign lane_ctrl.operator_kind      = operator_kind;
  assign lane_ctrl.gradient_direction = gradient_direction;

  for (genvar ch = 0; ch < NUM_LANES; ch++) begin : g_lane
    for (genvar k = 0; k < 9; k++) begin : g_tap
      assign lane_win[ch][k] = window_pixels[k][23 - 8 * ch -: 8];
    end
    ged_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (lane_ctrl),
      .win   (lane_win[ch]),
      .done  (lane_done[ch]),
      .value (lane_val[ch])
    );
  end

  assign all_done = &lane_done;
  assign out_free = !result_valid || !result_stall;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!is_drain && (!emit_now || column_count != '0)) state_next = S_WR;
          else if (emit_now) state_next = S_RD0;
        end
      end
      S_WR:    state_next = emit_q ? S_RD0 : S_IDLE;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_RD3;
      S_RD3:   state_next = S_START;
      S_START: state_next = S_CALC;
      S_CALC:  if (all_done && out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      pending_results <= '0;
      in_slot         <= '0;
      out_col         <= '0;
      out_row         <= '0;
      out_slot        <= '0;
      emit_q          <= 1'b0;
      wr_q            <= 1'b0;
    end else begin
      if (accept) begin
        emit_q <= emit_now;
        if (is_drain) begin
          wr_q <= 1'b0;
          if (emit_now) pending_results <= pending_results - PEND_W'(1);
        end else begin
          wr_q <= (column_count == '0);
          if (!emit_now) pending_results <= pending_results + PEND_W'(1);
          if (col_last) begin
            column_count <= '0;
            in_slot      <= slot_next(in_slot);
            row_count    <= in_last_row ? '0 : row_count + ROW_W'(1);
          end else begin
            column_count <= column_count + COL_W'(1);
          end
        end
      end
      if (state == S_CALC && all_done && out_free) begin
        if (out_eor) begin
          out_col  <= '0;
          out_slot <= slot_next(out_slot);
          out_row  <= out_eof ? '0 : out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_addr <= column_count;
      wr_slot <= in_slot;
      wr_data <= {pixel.red, pixel.green, pixel.blue};
    end
  end

  // merge stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_CALC && all_done && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC && all_done && out_free) begin
      result.edge_red     <= lane_val[0];
      result.edge_green   <= lane_val[1];
      result.edge_blue    <= lane_val[2];
      result.end_of_row   <= out_eor;
      result.end_of_frame <= out_eof;
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pending_results) <= MAX_WIDTH + 1)
    else $error("pending count out of range");

  a_empty_drain: assert property (@(posedge clk) disable iff (rst)
    accept && is_drain && pending_results == '0 |=> state == S_IDLE)
    else $error("empty drain started work");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    we |-> state == S_WR || (state == S_START && wr_q))
    else $error("row write outside its slot");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC && state_next == S_IDLE |=> result_valid)
    else $error("finished beat produced no result");

endmodule
